FILE: rtl/half_open_connection_tracker_core_defines.svh
// Assertion macros for the connection tracker.
`ifndef HALF_OPEN_CONNECTION_TRACKER_CORE_DEFINES_SVH
`define HALF_OPEN_CONNECTION_TRACKER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HOCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HOCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HOCT_ASSERT_SAME(label, ante, cons, msg)
`define HOCT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/hoct_pkg.sv
`timescale 1ns / 1ps
package hoct_pkg;
  localparam int CAPACITY = 1024;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam int FLAG_SYN_BIT = 1;
  localparam int FLAG_ACK_BIT = 4;

  localparam logic [2:0] ST_IGNORED       = 3'd0;
  localparam logic [2:0] ST_INSERTED      = 3'd1;
  localparam logic [2:0] ST_TRACKED       = 3'd2;
  localparam logic [2:0] ST_FULL          = 3'd3;
  localparam logic [2:0] ST_REMOVED       = 3'd4;
  localparam logic [2:0] ST_ACK_UNTRACKED = 3'd5;

  typedef struct packed {
    logic        valid;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [31:0] port_pair;
    logic [59:0] start_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
endpackage

FILE: rtl/hoct_ram.sv
`timescale 1ns / 1ps
module hoct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/half_open_connection_tracker_core.sv
`timescale 1ns / 1ps
// Half-open TCP connection tracker. Takes one parsed packet request at a time
// and returns one result (status, start time) per request. The table lives in
// one RAM and is searched by a single comparator walking every slot, one slot
// per cycle, for a SYN or ACK request on a TCP telemetry record; other requests
// skip the walk and go straight to the decision. The input is not ready while a
// request is in work. After reset a clearing pass writes every slot empty before
// the first request is taken.
`include "half_open_connection_tracker_core_defines.svh"
module half_open_connection_tracker_core
  import hoct_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // source_address, destination_address, source_port, destination_port,
  // protocol, tcp_flags, raw_time_field
  input  logic [175:0] s_tdata,
  // is_telemetry
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], start_time[62:3], zero pad [63]
  output logic [63:0]  m_tdata
);
  typedef enum logic [1:0] {CLEAR, IDLE, SCAN, DECIDE} state_t;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);

  state_t           state;
  logic [IDX_W-1:0] addr;       // clear / scan issue address
  logic             issue_done;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic             free_ok;
  logic [IDX_W-1:0] free_idx;
  logic [CNT_W-1:0] entry_count;

  // latched request
  logic        handled;
  logic [31:0] sa, da, pp;
  logic [7:0]  flags;
  logic [59:0] ts;

  logic [2:0]  out_status;
  logic [59:0] out_time;

  entry_t           rd_entry, wr_entry;
  logic [ENTRY_W-1:0] rd_raw;
  logic             we;
  logic [IDX_W-1:0] waddr;

  logic syn_only, ack, out_free, hit;
  logic [63:0] raw_in;

  assign raw_in   = s_tdata[175:112];
  assign syn_only = flags[FLAG_SYN_BIT] && !flags[FLAG_ACK_BIT];
  assign ack      = flags[FLAG_ACK_BIT];
  assign out_free = !m_tvalid || m_tready;
  assign rd_entry = entry_t'(rd_raw);
  assign hit      = rd_entry.valid && rd_entry.source_address == sa &&
                    rd_entry.destination_address == da && rd_entry.port_pair == pp;

  assign s_tready = (state == IDLE);
  assign m_tdata  = {1'b0, out_time, out_status};

  // write port: clearing pass, insert or remove
  always_comb begin
    we       = 1'b0;
    waddr    = addr;
    wr_entry = '0;
    if (state == CLEAR) begin
      we = 1'b1;
    end else if (state == DECIDE && out_free && handled) begin
      if (syn_only && !found && entry_count < CNT_W'(CAPACITY) && free_ok) begin
        we       = 1'b1;
        waddr    = free_idx;
        wr_entry = '{valid: 1'b1, source_address: sa, destination_address: da,
                     port_pair: pp, start_time: ts};
      end else if (ack && found) begin
        we    = 1'b1;
        waddr = found_idx;
      end
    end
  end

  hoct_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_entry),
    .raddr (addr),
    .rdata (rd_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CLEAR;
      addr        <= '0;
      issue_done  <= 1'b0;
      rd_vld      <= 1'b0;
      entry_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // DECIDE only issues when the output is free, so it never needs the clear
      if (m_tready && state != DECIDE) m_tvalid <= 1'b0;
      unique case (state)
        CLEAR: begin
          if (addr == LAST) begin
            addr  <= '0;
            state <= IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        IDLE: begin
          if (s_tvalid) begin
            sa      <= s_tdata[31:0];
            da      <= s_tdata[63:32];
            pp      <= {s_tdata[79:64], s_tdata[95:80]};
            flags   <= s_tdata[111:104];
            handled <= s_tuser[0] && s_tdata[103:96] == PROTO_TCP;
            // byte swap, keep upper 48 bits, shift right by 4
            ts <= {raw_in[7:0], raw_in[15:8], raw_in[23:16], raw_in[31:24],
                   raw_in[39:32], raw_in[47:40], 12'd0};
            found      <= 1'b0;
            free_ok    <= 1'b0;
            addr       <= '0;
            issue_done <= 1'b0;
            rd_vld     <= 1'b0;
            if (s_tuser[0] && s_tdata[103:96] == PROTO_TCP &&
                (s_tdata[104 + FLAG_SYN_BIT] || s_tdata[104 + FLAG_ACK_BIT])) begin
              state <= SCAN;
            end else begin
              state <= DECIDE;
            end
          end
        end
        SCAN: begin
          rd_vld <= !issue_done;
          rd_idx <= addr;
          if (!issue_done) begin
            if (addr == LAST) issue_done <= 1'b1;
            else addr <= addr + 1'b1;
          end
          if (rd_vld) begin
            if (hit && !found) begin
              found     <= 1'b1;
              found_idx <= rd_idx;
            end
            if (!rd_entry.valid && !free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= rd_idx;
            end
            if (rd_idx == LAST) state <= DECIDE;
          end
        end
        DECIDE: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_time   <= handled ? ts : '0;
            if (handled && syn_only) begin
              if (found) begin
                out_status <= ST_TRACKED;
              end else if (entry_count < CNT_W'(CAPACITY) && free_ok) begin
                out_status  <= ST_INSERTED;
                entry_count <= entry_count + 1'b1;
              end else begin
                out_status <= ST_FULL;
              end
            end else if (handled && ack) begin
              if (found) begin
                out_status <= ST_REMOVED;
                if (entry_count != '0) entry_count <= entry_count - 1'b1;
              end else begin
                out_status <= ST_ACK_UNTRACKED;
              end
            end else begin
              out_status <= ST_IGNORED;
            end
            state <= IDLE;
          end
        end
        default: state <= CLEAR;
      endcase
    end
  end

  `HOCT_ASSERT_SAME(a_count_bound, 1'b1, entry_count <= CNT_W'(CAPACITY), "count over capacity")
  `HOCT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
  `HOCT_ASSERT_SAME(a_result_from_decide, $rose(m_tvalid), $past(state == DECIDE), "stray result")
  `HOCT_ASSERT_SAME(a_no_write_in_scan, state == SCAN, !we, "table write during scan")
endmodule

FILE: dv/half_open_connection_tracker_core_tb.sv
`timescale 1ns / 1ps
module half_open_connection_tracker_core_tb;
  import hoct_pkg::*;

  localparam int N_RANDOM   = 900;
  localparam int KEY_POOL   = 16;
  localparam int STALL_MAX  = 20000;  // covers clear pass plus a full walk and stalls
  localparam int DRAIN_WAIT = 1100;   // one full walk

  typedef struct packed {
    logic        tele;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  proto;
    logic [7:0]  flags;
    logic [63:0] raw;
  } pkt_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [59:0] start_time;
  } verdict_t;

  typedef struct packed {
    pkt_t     pkt;
    logic     typed;   // expected result given in the row
    verdict_t want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [175:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;

  always #5 clk = ~clk;

  half_open_connection_tracker_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Shadow of the connection set, keyed by {sa, da, sp, dp}.
  bit        open_conn[bit [95:0]];
  int        open_count;
  verdict_t  pending_results[$];
  row_t      rows[$];
  logic [95:0] key_pool[KEY_POOL];
  int        errors;
  int        accepted_reqs;
  int        idle_cycles;
  bit        calm;
  bit        all_sent;

  function automatic logic [59:0] derive_start(input logic [63:0] raw);
    logic [63:0] swapped;
    swapped = {<<8{raw}};
    return {swapped[63:16], 12'h000};
  endfunction

  // Applies one packet to the shadow set and returns its status and time.
  function automatic verdict_t track_packet(input pkt_t p);
    verdict_t    v;
    logic [95:0] key;
    bit          hit;
    v = '0;
    key = {p.sa, p.da, p.sp, p.dp};
    if (!p.tele || p.proto != PROTO_TCP) return v;
    v.start_time = derive_start(p.raw);
    hit = open_conn.exists(key);
    if (p.flags[FLAG_SYN_BIT] && !p.flags[FLAG_ACK_BIT]) begin
      if (hit) v.status = ST_TRACKED;
      else if (open_count >= CAPACITY) v.status = ST_FULL;
      else begin
        open_conn[key] = 1'b1;
        open_count++;
        v.status = ST_INSERTED;
      end
    end else if (p.flags[FLAG_ACK_BIT]) begin
      if (hit) begin
        open_conn.delete(key);
        open_count--;
        v.status = ST_REMOVED;
      end else v.status = ST_ACK_UNTRACKED;
    end else v.status = ST_IGNORED;
    return v;
  endfunction

  function automatic pkt_t random_packet();
    pkt_t        p;
    logic [95:0] key;
    int          roll;
    key = (($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL - 1)]
           : {$urandom, $urandom, $urandom});
    {p.sa, p.da, p.sp, p.dp} = key;
    p.tele  = ($urandom_range(99) >= 5);
    p.proto = ($urandom_range(99) < 5) ? 8'($urandom) : PROTO_TCP;
    p.raw   = {$urandom, $urandom};
    p.flags = 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 50) begin
      p.flags[FLAG_SYN_BIT] = 1'b1;
      p.flags[FLAG_ACK_BIT] = 1'b0;
    end else if (roll < 90) begin
      p.flags[FLAG_ACK_BIT] = 1'b1;
    end
    return p;
  endfunction

  function automatic row_t mk(input pkt_t p, input logic typed, input logic [2:0] st,
                              input logic [59:0] t);
    row_t r;
    r.pkt = p;
    r.typed = typed;
    r.want.status = st;
    r.want.start_time = t;
    return r;
  endfunction

  // Directed rows: ignored kinds, ack on an empty table, key extremes,
  // syn+ack treated as ack, repeated syn.
  initial begin
    pkt_t p;
    p = '{1'b0, '1, '1, '1, '1, PROTO_TCP, 8'h02, '1};
    rows.push_back(mk(p, 1'b1, ST_IGNORED, '0));
    p.tele = 1'b1; p.proto = 8'd17;
    rows.push_back(mk(p, 1'b1, ST_IGNORED, '0));
    p.proto = 8'hff;
    rows.push_back(mk(p, 1'b1, ST_IGNORED, '0));
    p = '{1'b1, '0, '0, '0, '0, PROTO_TCP, 8'h00, '0};
    rows.push_back(mk(p, 1'b1, ST_IGNORED, '0));
    p.flags = 8'h10;
    rows.push_back(mk(p, 1'b1, ST_ACK_UNTRACKED, '0));
    p.flags = 8'h02;
    rows.push_back(mk(p, 1'b1, ST_INSERTED, '0));
    rows.push_back(mk(p, 1'b1, ST_TRACKED, '0));
    p.flags = 8'hff;
    rows.push_back(mk(p, 1'b1, ST_REMOVED, '0));
    rows.push_back(mk(p, 1'b1, ST_ACK_UNTRACKED, '0));
    p = '{1'b1, '1, '1, '1, '1, PROTO_TCP, 8'hef, '1};
    rows.push_back(mk(p, 1'b1, ST_INSERTED, 60'hffffffffffff000));
    p.flags = 8'hed;
    rows.push_back(mk(p, 1'b1, ST_IGNORED, 60'hffffffffffff000));
    p.flags = 8'h12; p.raw = 64'h0123456789abcdef;
    rows.push_back(mk(p, 1'b0, ST_IGNORED, '0));
    p.flags = 8'h02; p.sa = 32'h8000_0001; p.raw = 64'h8000_0000_0000_0001;
    rows.push_back(mk(p, 1'b0, ST_IGNORED, '0));
    p.dp = 16'h0; p.raw = 64'hfedc_ba98_7654_3210;
    rows.push_back(mk(p, 1'b0, ST_IGNORED, '0));
    p.flags = 8'h10;
    rows.push_back(mk(p, 1'b0, ST_IGNORED, '0));
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom, $urandom};
    for (int i = 0; i < N_RANDOM; i++) rows.push_back(mk(random_packet(), 1'b0, '0, '0));
  end

  // Request side: predicts on each handshake, then presents the next row.
  initial begin
    row_t     cur;
    verdict_t v;
    int       next_row;
    errors = 0;
    accepted_reqs = 0;
    open_count = 0;
    all_sent = 1'b0;
    calm = 1'b0;
    next_row = 0;
    cur = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    forever begin
      @(posedge clk);
      if (s_tvalid && s_tready) begin
        v = track_packet(cur.pkt);
        pending_results.push_back(cur.typed ? cur.want : v);
        accepted_reqs++;
        calm = (accepted_reqs >= 400 && accepted_reqs < 550);
      end
      if (!s_tvalid || s_tready) begin
        if (next_row >= rows.size()) begin
          s_tvalid <= 1'b0;
          all_sent = 1'b1;
        end else if (!calm && $urandom_range(99) < 37) begin
          s_tvalid <= 1'b0;
        end else begin
          cur = rows[next_row];
          next_row++;
          s_tvalid <= 1'b1;
          s_tuser  <= cur.pkt.tele;
          s_tdata  <= {cur.pkt.raw, cur.pkt.flags, cur.pkt.proto, cur.pkt.dp, cur.pkt.sp,
                       cur.pkt.da, cur.pkt.sa};
        end
      end
    end
  end

  // Result side: random backpressure, checks against the oldest expectation.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst) begin
      m_tready <= calm || ($urandom_range(99) >= 37);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d start_time=%h", $time,
                   m_tdata[2:0], m_tdata[62:3]);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[2:0] !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     m_tdata[2:0]);
            errors++;
          end
          if (m_tdata[62:3] !== want.start_time) begin
            $display("%0t: start_time expected %h actual %h", $time, want.start_time,
                     m_tdata[62:3]);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_MAX) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    wait (all_sent);
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: half_open_connection_tracker_core.f
+incdir+rtl
rtl/hoct_pkg.sv
rtl/hoct_ram.sv
rtl/half_open_connection_tracker_core.sv
dv/half_open_connection_tracker_core_tb.sv
